>>> design/scfla_pkg.sv
package scfla_pkg;

  localparam int unsigned CLASS_COUNT = 8;
  localparam int unsigned CLASS_W     = 3;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned BYTES_W     = 16;
  localparam int unsigned SIZE_W      = 9;
  localparam logic [BYTES_W-1:0] MAX_BYTES = 16'd256;
  localparam logic [BYTES_W-1:0] MID_LIMIT = 16'd128;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_FULL_FREE = 2'd3
  } status_t;

  typedef struct packed {
    logic               kind;
    logic [BYTES_W-1:0] req_bytes;
    logic [CLASS_W-1:0] free_class;
    logic [SLOT_W-1:0]  free_slot;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [CLASS_W-1:0] grant_class;
    logic [SLOT_W-1:0]  grant_slot;
    logic [SIZE_W-1:0]  class_bytes;
  } rsp_t;

  function automatic logic [CLASS_W-1:0] size_to_class(input logic [BYTES_W-1:0] n);
    logic [CLASS_W-1:0] c;
    if (n <= 16'd8) c = 3'd0;
    else if (n <= 16'd12) c = 3'd1;
    else if (n <= 16'd16) c = 3'd2;
    else if (n <= 16'd24) c = 3'd3;
    else if (n <= 16'd32) c = 3'd4;
    else if (n <= 16'd64) c = 3'd5;
    else if (n <= MID_LIMIT) c = 3'd6;
    else c = 3'd7;
    return c;
  endfunction

  function automatic logic [SIZE_W-1:0] class_size(input logic [CLASS_W-1:0] c);
    logic [SIZE_W-1:0] s;
    case (c)
      3'd0: s = 9'd8;
      3'd1: s = 9'd12;
      3'd2: s = 9'd16;
      3'd3: s = 9'd24;
      3'd4: s = 9'd32;
      3'd5: s = 9'd64;
      3'd6: s = 9'd128;
      3'd7: s = 9'd256;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

>>> design/size_class_free_list_allocator_unit.sv
// channel | dir | handshake               | payload
// req     | in  | req_valid / req_ready   | scfla_pkg::req_t
// rsp     | out | rsp_valid / rsp_ready   | scfla_pkg::rsp_t
// one request per cycle unless rsp stalls; result registered in s1, then in rsp
// s1 step: count update, stack write or stack read; rsp step: result register
// stack (8 x 2^clog2(SLOTS_PER_CLASS) words), one port, used at most once per request
// never-popped stack entries come from a per-class low-water mark, so no clearing pass
// reset (rst, synchronous) restores all counts; a stalled rsp holds both stages
module size_class_free_list_allocator_unit #(
  parameter int unsigned SLOTS_PER_CLASS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  scfla_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output scfla_pkg::rsp_t rsp
);
  import scfla_pkg::*;

  localparam int unsigned CW    = $clog2(SLOTS_PER_CLASS + 1);
  localparam int unsigned IW    = $clog2(SLOTS_PER_CLASS);
  localparam int unsigned AW    = CLASS_W + IW;
  localparam int unsigned DEPTH = CLASS_COUNT << IW;
  localparam logic [CW-1:0] FULL = CW'(SLOTS_PER_CLASS);

  logic [CW-1:0] cnt [CLASS_COUNT];
  logic [CW-1:0] wm  [CLASS_COUNT];
  logic [SLOT_W-1:0] stack_mem [DEPTH];
  logic [SLOT_W-1:0] rd_data;

  logic               s1_valid;
  status_t            s1_status;
  logic [CLASS_W-1:0] s1_class;
  logic [SIZE_W-1:0]  s1_bytes;
  logic               s1_use_mem;
  logic [SLOT_W-1:0]  s1_fallback;

  logic               accept, s2_free, s1_adv;
  logic               is_alloc, too_large, do_pop, do_push, fresh;
  logic [CLASS_W-1:0] acls, sel;
  logic [CW-1:0]      c, w, c_m1;
  logic [AW-1:0]      addr;
  status_t            status_next;
  logic [CLASS_W-1:0] class_next;
  logic [SIZE_W-1:0]  bytes_next;

  assign s2_free   = !rsp_valid || rsp_ready;
  assign s1_adv    = s1_valid && s2_free;
  assign req_ready = !s1_valid || s1_adv;
  assign accept    = req_valid && req_ready;

  always_comb begin
    is_alloc  = (req.kind == KIND_ALLOC);
    too_large = (req.req_bytes > MAX_BYTES);
    acls      = size_to_class(req.req_bytes);
    sel       = is_alloc ? acls : req.free_class;
    c         = cnt[sel];
    w         = wm[sel];
    c_m1      = c - CW'(1);
    fresh     = (c == w);
    do_pop    = accept && is_alloc && !too_large && (c != '0);
    do_push   = accept && !is_alloc && (c < FULL);
    addr      = is_alloc ? {sel, c_m1[IW-1:0]} : {sel, c[IW-1:0]};
    status_next = ST_OK;
    class_next  = '0;
    bytes_next  = '0;
    if (is_alloc) begin
      if (too_large) begin
        status_next = ST_TOO_LARGE;
      end else begin
        class_next = acls;
        bytes_next = class_size(acls);
        if (c == '0) status_next = ST_NO_SLOT;
      end
    end else if (c >= FULL) begin
      status_next = ST_FULL_FREE;
    end
  end

  // count and low-water mark per class
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLASS_COUNT; i++) begin
        cnt[i] <= FULL;
        wm[i]  <= FULL;
      end
    end else begin
      if (do_pop) begin
        cnt[sel] <= c_m1;
        if (fresh) wm[sel] <= c_m1;
      end else if (do_push) begin
        cnt[sel] <= c + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) stack_mem[addr] <= req.free_slot;
    if (do_pop) rd_data <= stack_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status   <= status_next;
      s1_class    <= class_next;
      s1_bytes    <= bytes_next;
      s1_use_mem  <= do_pop && !fresh;
      s1_fallback <= do_pop ? SLOT_W'(c_m1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.status      <= s1_status;
      rsp.grant_class <= s1_class;
      rsp.grant_slot  <= s1_use_mem ? rd_data : s1_fallback;
      rsp.class_bytes <= s1_bytes;
    end
  end

endmodule

>>> design/scfla_checker.sv
module scfla_checker (
  input logic            clk,
  input logic            rst,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input scfla_pkg::rsp_t rsp
);
  import scfla_pkg::*;

  // stalled result transfer holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  a_too_large: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_TOO_LARGE |->
      rsp.grant_class == '0 && rsp.grant_slot == '0 && rsp.class_bytes == '0)
    else $error("too-large result carries data");

  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NO_SLOT |->
      rsp.grant_slot == '0 && rsp.class_bytes == class_size(rsp.grant_class))
    else $error("no-slot result inconsistent");

  a_full_free: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL_FREE |->
      rsp.grant_class == '0 && rsp.grant_slot == '0 && rsp.class_bytes == '0)
    else $error("full-free result carries data");

endmodule

bind size_class_free_list_allocator_unit scfla_checker u_scfla_checker (.*);
